>>> hdl/mdh_pkg.sv
// Shared types and constants for the masked difference histogram.
// Holds the controller state type, the command and status structs and the fixed widths.
// No dependencies.
package mdh_pkg;

	// Store geometry.
	localparam int MAX_HALF_BINS = 32;
	localparam int BIN_COUNT     = 2 * MAX_HALF_BINS;
	localparam int BIN_W         = 6;
	localparam int CNT_W         = 17;
	localparam int LEVEL_W       = 17;
	localparam int VAL_W         = 16;
	localparam logic [BIN_W-1:0] HALF_RESET   = BIN_W'(MAX_HALF_BINS);
	localparam logic [CNT_W-1:0] SAMPLE_LIMIT = CNT_W'(65536);

	// Offset arithmetic: off = ((mag * (100*H - 1)) >> 16) / 100.
	// The divide by 100 is a multiply by ceil(2^22 / 100), exact for inputs below 3200.
	localparam int COEF_W      = 12;
	localparam int PROD_W      = VAL_W + COEF_W;
	localparam int QIN_W       = PROD_W - 16;
	localparam int RECIP_W     = 16;
	localparam int QPROD_W     = QIN_W + RECIP_W;
	localparam int RECIP_SHIFT = 22;
	localparam int OFF_W       = 5;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(41944);

	// Readout divider: one quotient bit per cycle.
	localparam int DIV_STEPS = LEVEL_W;
	localparam int DIV_CNT_W = 5;

	// Controller states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PROD,
		ST_QUOT,
		ST_BIN,
		ST_UPD,
		ST_RD,
		ST_DLOAD,
		ST_DIV,
		ST_EMIT
	} mdh_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic prod;
		logic quot;
		logic bin_rd;
		logic upd;
		logic rd_out;
		logic div_start;
		logic emit;
		logic clear;
		logic idx_inc;
	} mdh_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic last;
		logic idx_last;
		logic div_done;
	} mdh_stat_t;

endpackage

>>> hdl/mdh_div.sv
// Iterative restoring divider for the readout level count * 65536 / peak.
// Depends on mdh_pkg. The dividend never exceeds the divisor, so the quotient fits LEVEL_W bits.
module mdh_div import mdh_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [CNT_W-1:0]   dividend,
	input  logic [CNT_W-1:0]   divisor,
	output logic [LEVEL_W-1:0] quotient,
	output logic               done
);

	logic [CNT_W:0]         rem_q;
	logic [LEVEL_W-1:0]     quo_q;
	logic [DIV_CNT_W-1:0]   cnt_q;
	logic [CNT_W:0]         diff;
	logic                   ge;
	logic [CNT_W:0]         nxt;

	// One compare and subtract per cycle.
	assign diff = rem_q - {1'b0, divisor};
	assign ge   = (rem_q >= {1'b0, divisor});
	assign nxt  = ge ? diff : rem_q;

	// Step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= DIV_CNT_W'(DIV_STEPS);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - DIV_CNT_W'(1);
		end
	end

	// Partial remainder and quotient bits; the low dividend bits are all zero.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, dividend};
			quo_q <= '0;
		end else if (cnt_q != '0) begin
			rem_q <= {nxt[CNT_W-1:0], 1'b0};
			quo_q <= {quo_q[LEVEL_W-2:0], ge};
		end
	end

	assign quotient = quo_q;
	assign done     = (cnt_q == '0);

endmodule

>>> hdl/mdh_datapath.sv
// Datapath: configuration register, bin arithmetic, count store, peak and readout registers.
// Depends on mdh_pkg and mdh_div; driven by the command struct from mdh_ctrl.
module mdh_datapath import mdh_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [BIN_W-1:0]   cfg_wdata,
	input  logic [VAL_W-1:0]   value_a,
	input  logic [VAL_W-1:0]   value_b,
	input  logic               selected,
	input  logic               last,
	input  mdh_cmd_t           cmd,
	output mdh_stat_t          stat,
	output logic               strobe,
	output logic [BIN_W-1:0]   bin_id,
	output logic [LEVEL_W-1:0] bin_level,
	output logic               last_bin
);

	logic [BIN_W-1:0]   half_q;
	logic [BIN_W-1:0]   h_eff;
	logic [BIN_W-1:0]   h_q;
	logic [VAL_W-1:0]   a_q;
	logic [VAL_W-1:0]   b_q;
	logic               sel_q;
	logic               last_q;
	logic               ge_q;
	logic [PROD_W-1:0]  prod_q;
	logic [OFF_W-1:0]   off_q;
	logic [BIN_W-1:0]   bin_q;
	logic [CNT_W-1:0]   rd_q;
	logic               rd_hit_q;
	logic [BIN_W-1:0]   idx_q;
	logic [CNT_W-1:0]   peak_q;
	logic [BIN_COUNT-1:0] valid_q;
	logic               strobe_q;
	logic [BIN_W-1:0]   out_idx_q;
	logic [LEVEL_W-1:0] out_level_q;
	logic               out_last_q;
	logic [CNT_W-1:0]   mem [BIN_COUNT];

	logic [VAL_W-1:0]   mag;
	logic [COEF_W-1:0]  coeff;
	logic [QPROD_W-1:0] qprod;
	logic [BIN_W:0]     limit;
	logic [BIN_W:0]     bin_raw;
	logic [BIN_W-1:0]   bin_next;
	logic [BIN_W-1:0]   rd_addr;
	logic [CNT_W-1:0]   cnt_cur;
	logic [CNT_W-1:0]   cnt_inc;
	logic               do_write;
	logic [LEVEL_W-1:0] quotient;
	logic               div_done;

	// Effective half-bin count: zero acts as one, large values clamp to the maximum.
	always_comb begin
		if (half_q == '0) begin
			h_eff = BIN_W'(1);
		end else if (half_q > BIN_W'(MAX_HALF_BINS)) begin
			h_eff = BIN_W'(MAX_HALF_BINS);
		end else begin
			h_eff = half_q;
		end
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q <= HALF_RESET;
		end else if (cfg_we) begin
			half_q <= cfg_wdata;
		end
	end

	// Magnitude of the difference times (100*H - 1).
	assign mag   = ge_q ? (a_q - b_q) : (b_q - a_q);
	assign coeff = COEF_W'(h_q) * COEF_W'(100) - COEF_W'(1);

	// Divide by 6553600 as a shift by 16 and a reciprocal multiply by 1/100.
	assign qprod = QPROD_W'(prod_q[PROD_W-1 -: QIN_W]) * QPROD_W'(RECIP);

	// Bin from the offset, clamped at 2H-1.
	assign limit    = {h_q, 1'b0} - (BIN_W+1)'(1);
	assign bin_raw  = ge_q ? ({1'b0, h_q} + (BIN_W+1)'(off_q))
	                       : ({1'b0, h_q} - (BIN_W+1)'(off_q));
	assign bin_next = (bin_raw > limit) ? limit[BIN_W-1:0] : bin_raw[BIN_W-1:0];

	// Store read address and the count seen there; unwritten entries read as zero.
	assign rd_addr  = cmd.bin_rd ? bin_next : idx_q;
	assign cnt_cur  = rd_hit_q ? rd_q : '0;
	assign cnt_inc  = cnt_cur + CNT_W'(1);
	assign do_write = cmd.upd && sel_q && (cnt_cur < SAMPLE_LIMIT);

	// Item capture and arithmetic pipeline registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q    <= value_a;
			b_q    <= value_b;
			sel_q  <= selected;
			last_q <= last;
			h_q    <= h_eff;
			ge_q   <= (value_a >= value_b);
		end
		if (cmd.prod) begin
			prod_q <= PROD_W'(mag) * PROD_W'(coeff);
		end
		if (cmd.quot) begin
			off_q <= qprod[RECIP_SHIFT +: OFF_W];
		end
		if (cmd.bin_rd) begin
			bin_q <= bin_next;
		end
	end

	// Count store: one registered read port and one write port.
	always_ff @(posedge clk) begin
		if (cmd.bin_rd || cmd.rd_out) begin
			rd_q <= mem[rd_addr];
		end
		if (do_write) begin
			mem[bin_q] <= cnt_inc;
		end
	end

	// Entry valid bits, peak count and readout index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			peak_q   <= '0;
			idx_q    <= '0;
			rd_hit_q <= 1'b0;
		end else begin
			if (cmd.bin_rd || cmd.rd_out) begin
				rd_hit_q <= valid_q[rd_addr];
			end
			if (cmd.clear) begin
				valid_q <= '0;
				peak_q  <= '0;
			end else if (do_write) begin
				valid_q[bin_q] <= 1'b1;
				if (cnt_inc > peak_q) begin
					peak_q <= cnt_inc;
				end
			end
			if (cmd.load) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + BIN_W'(1);
			end
		end
	end

	// Readout divider.
	mdh_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (cnt_cur),
		.divisor  (peak_q),
		.quotient (quotient),
		.done     (div_done)
	);

	// Result beat registers; a zero peak gives a zero level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_idx_q   <= idx_q;
			out_level_q <= (peak_q == '0) ? '0 : quotient;
			out_last_q  <= (idx_q == limit[BIN_W-1:0]);
		end
	end

	assign stat.last     = last_q;
	assign stat.idx_last = (idx_q == limit[BIN_W-1:0]);
	assign stat.div_done = div_done;

	assign strobe    = strobe_q;
	assign bin_id    = out_idx_q;
	assign bin_level = out_level_q;
	assign last_bin  = out_last_q;

endmodule

>>> hdl/mdh_ctrl.sv
// Controller state machine: sequences the count update and the per-bin readout.
// Depends on mdh_pkg; talks to mdh_datapath through the command and status structs.
module mdh_ctrl import mdh_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  mdh_stat_t stat,
	output mdh_cmd_t  cmd,
	output logic      busy
);

	mdh_state_t state_q;
	mdh_state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_PROD;
				end
			end
			ST_PROD: begin
				cmd.prod = 1'b1;
				state_d  = ST_QUOT;
			end
			ST_QUOT: begin
				cmd.quot = 1'b1;
				state_d  = ST_BIN;
			end
			ST_BIN: begin
				cmd.bin_rd = 1'b1;
				state_d    = ST_UPD;
			end
			ST_UPD: begin
				cmd.upd = 1'b1;
				state_d = stat.last ? ST_RD : ST_IDLE;
			end
			ST_RD: begin
				cmd.rd_out = 1'b1;
				state_d    = ST_DLOAD;
			end
			ST_DLOAD: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIV;
			end
			ST_DIV: begin
				if (stat.div_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				cmd.emit = 1'b1;
				if (stat.idx_last) begin
					cmd.clear = 1'b1;
					state_d   = ST_IDLE;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = ST_RD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule

>>> hdl/masked_difference_histogram_top.sv
// Top level of the masked difference histogram.
// Depends on mdh_pkg, mdh_ctrl and mdh_datapath (which holds mdh_div).
//
// An item is taken when start is high and busy is low. A selected item adds one
// to the bin of its signed difference; the count read-modify-write goes through
// a multiplier, a reciprocal multiplier and the registered store read port, so
// an item that does not end a set holds busy through the product, quotient, bin
// and update states, and no new item is taken until busy falls again. An item
// with last set then reads out all 2H bins: each bin takes a store read, a
// divider load, the bit-serial divider (17 steps, then done) and an emit. Each
// result beat is shown for exactly one cycle, marked by strobe, and cannot be
// held off; the last beat of a run has last_bin set. After the readout the store
// and peak are clear. half_bin_count may be written only while busy is low.
module masked_difference_histogram_top import mdh_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [BIN_W-1:0]   cfg_wdata,
	input  logic               start,
	output logic               busy,
	input  logic [VAL_W-1:0]   value_a,
	input  logic [VAL_W-1:0]   value_b,
	input  logic               selected,
	input  logic               last,
	output logic               strobe,
	output logic [BIN_W-1:0]   bin_id,
	output logic [LEVEL_W-1:0] bin_level,
	output logic               last_bin
);

	mdh_cmd_t  cmd;
	mdh_stat_t stat;

	// Sequencer.
	mdh_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// Arithmetic, store and result registers.
	mdh_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.value_a   (value_a),
		.value_b   (value_b),
		.selected  (selected),
		.last      (last),
		.cmd       (cmd),
		.stat      (stat),
		.strobe    (strobe),
		.bin_id    (bin_id),
		.bin_level (bin_level),
		.last_bin  (last_bin)
	);

	// A result beat only follows a busy cycle.
	a_strobe_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy))
		else $error("result beat without a preceding busy cycle");

	// The final beat of a readout leaves the block idle.
	a_last_bin_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last_bin |-> !busy)
		else $error("block still busy after the final readout beat");

	// A beat that is not the final one means the readout is still running.
	a_readout_continues: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last_bin |-> busy)
		else $error("readout stopped before the final bin");

	// An accepted item always starts work.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not raise busy");

endmodule
